### design/tilt_complementary_filter_assert.svh
// Assertion macros used by the tilt filter checker.
`ifndef TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_ASSERT_SVH

// Check a property on every rising edge while out of reset.
`define TCF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define TCF_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/tcf_pkg.sv
// Shared types, constants and the arctangent table of the tilt filter.
package tcf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 7;
  localparam int TBL_LEN          = 24;
  localparam int TBL_FRAC         = 20;
  localparam int GYRO_DIVISOR     = 64000;
  localparam int CFG_IDX_W        = 8;
  localparam int CFG_DATA_W       = 17;

  localparam logic [15:0] RST_OFFSET = 16'd0;
  localparam logic [16:0] RST_WEIGHT = 17'd64225;
  localparam logic [14:0] RST_LIMIT  = 15'd5760;
  localparam logic [16:0] Q16_ONE    = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFS_ROLL  = 8'd0,
    CFG_OFS_PITCH = 8'd1,
    CFG_WEIGHT    = 8'd2,
    CFG_LIMIT     = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic        [11:0] elapsed_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic               flipped;
  } out_word_t;

  // Settings as the back end sees them: weight already clamped to one.
  typedef struct packed {
    logic signed [15:0] offset_roll;
    logic signed [15:0] offset_pitch;
    logic        [16:0] weight;
    logic        [14:0] flip_limit;
  } cfg_t;

  // Arctangent of 2^-i in 2^-20 degree, rounded.
  function automatic logic [25:0] atan_entry(logic [4:0] i);
    logic [25:0] v;
    unique case (i)
      5'd0:  v = 26'd47185920;
      5'd1:  v = 26'd27855475;
      5'd2:  v = 26'd14718068;
      5'd3:  v = 26'd7471121;
      5'd4:  v = 26'd3750058;
      5'd5:  v = 26'd1876857;
      5'd6:  v = 26'd938658;
      5'd7:  v = 26'd469357;
      5'd8:  v = 26'd234682;
      5'd9:  v = 26'd117342;
      5'd10: v = 26'd58671;
      5'd11: v = 26'd29335;
      5'd12: v = 26'd14668;
      5'd13: v = 26'd7334;
      5'd14: v = 26'd3667;
      5'd15: v = 26'd1833;
      5'd16: v = 26'd917;
      5'd17: v = 26'd458;
      5'd18: v = 26'd229;
      5'd19: v = 26'd115;
      5'd20: v = 26'd57;
      5'd21: v = 26'd29;
      5'd22: v = 26'd14;
      5'd23: v = 26'd7;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

endpackage

### design/tcf_front.sv
// Front end: setting registers and a two-word queue of accepted samples.
module tcf_front import tcf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_word_t              in_word_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  q_valid_o,
  output in_word_t              q_word_o,
  input  logic                  q_take_i,
  output cfg_t                  cfg_o
);

  logic signed [15:0] ofs_roll_q, ofs_pitch_q;
  logic        [16:0] weight_q;
  logic        [14:0] limit_q;

  in_word_t    mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_take;

  // Write settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_roll_q  <= RST_OFFSET;
      ofs_pitch_q <= RST_OFFSET;
      weight_q    <= RST_WEIGHT;
      limit_q     <= RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFS_ROLL:  ofs_roll_q  <= cfg_data_i[15:0];
        CFG_OFS_PITCH: ofs_pitch_q <= cfg_data_i[15:0];
        CFG_WEIGHT:    weight_q    <= cfg_data_i;
        CFG_LIMIT:     limit_q     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Clamp the weight to one
  always_comb begin
    cfg_o.offset_roll  = ofs_roll_q;
    cfg_o.offset_pitch = ofs_pitch_q;
    cfg_o.weight       = (weight_q > Q16_ONE) ? Q16_ONE : weight_q;
    cfg_o.flip_limit   = limit_q;
  end

  assign full      = (cnt_q == 2'd2);
  assign do_push   = push && !full;
  assign q_valid_o = (cnt_q != 2'd0);
  assign do_take   = q_take_i && q_valid_o;
  assign q_word_o  = mem_q[rd_ptr_q];

  // Store incoming words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= in_word_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_take) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_take) cnt_q <= cnt_q + 2'd1;
      else if (!do_push && do_take) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

### design/tcf_back.sv
// Back end: square root, CORDIC angles, gyro steps, blend and result word.
module tcf_back import tcf_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  in_word_t  q_word_i,
  output logic      q_take_o,
  input  cfg_t      cfg_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int NSTEP = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;
  localparam int EW    = F + 9;
  localparam int AW    = F + 10;
  localparam int XW    = 36;
  localparam int ZW    = 30;
  localparam int DW    = 29 + F;
  localparam int QW    = DW - 15;
  localparam int SW    = QW + 2;
  localparam int PW    = SW + 18;
  localparam int BW    = SW + 19;
  localparam int CW    = EW + 15;
  localparam int RSH   = TBL_FRAC - F;
  // The divisor is 2^9 times an odd factor below 2^7; the odd part is done by a
  // reciprocal multiply that is exact for every NW-bit dividend.
  localparam int DSH   = 9;
  localparam int DODD  = GYRO_DIVISOR >> DSH;
  localparam int NW    = DW - DSH;
  localparam int RK    = NW + 7;
  localparam logic [NW:0] RECIP =
    (NW+1)'(((longint'(1) << RK) + longint'(DODD - 1)) / longint'(DODD));
  localparam logic signed [ZW-1:0] ZRND  = ZW'(1) <<< (RSH - 1);
  localparam logic signed [ZW-1:0] Z90   = ZW'(90) <<< TBL_FRAC;
  localparam logic signed [BW-1:0] LIM   = BW'(180) <<< F;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_A, ST_SQ_B, ST_SQRT, ST_CINIT, ST_CITER, ST_CDONE,
    ST_GINIT, ST_GDIV, ST_BMUL1, ST_BMUL2, ST_BSUM, ST_FIN
  } state_e;

  state_e state_q;
  in_word_t item_q;

  logic [31:0] sq_q, v_q, r_q, bit_q;
  logic [3:0]  sc_q;

  logic signed [17:0]   cx_q, cy_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [4:0]           i_q;
  logic                 zero_q, which_q;

  logic signed [AW-1:0] acc_q [2];
  logic signed [EW-1:0] est_q [2];
  logic [DW-1:0]        n_q   [2];
  logic                 neg_q [2];
  logic                 ch_q;
  logic signed [PW-1:0] p1_q, p2_q;

  logic        out_valid_q;
  out_word_t   out_q;

  // Square root step
  logic [32:0] rb;
  assign rb = {1'b0, r_q} + {1'b0, bit_q};

  // CORDIC step
  logic signed [XW-1:0] xe, ye, xsh, ysh;
  logic signed [ZW-1:0] at_s, zr;
  assign xe   = XW'(cx_q) <<< 16;
  assign ye   = XW'(cy_q) <<< 16;
  assign xsh  = x_q >>> i_q;
  assign ysh  = y_q >>> i_q;
  assign at_s = ZW'($signed({1'b0, atan_entry(i_q)}));
  assign zr   = (z_q + ZRND) >>> RSH;

  // Gyro products
  logic signed [16:0] diff [2];
  logic signed [29:0] m    [2];
  logic [28:0]        mag  [2];
  assign diff[0] = 17'(item_q.rate_x) - 17'(cfg_i.offset_roll);
  assign diff[1] = 17'(item_q.rate_y) - 17'(cfg_i.offset_pitch);
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      m[c]   = 30'(diff[c]) * 30'($signed({1'b0, item_q.elapsed_ms}));
      mag[c] = 29'((m[c] < 0) ? -m[c] : m[c]);
    end
  end

  // Divide by the constant: drop the power of two, multiply by the reciprocal
  logic [2*NW:0] prod [2];
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      prod[c] = (2*NW+1)'(n_q[c][DW-1:DSH]) * (2*NW+1)'(RECIP);
    end
  end

  // Blend arithmetic
  logic signed [QW:0]   dq;
  logic signed [SW-1:0] gsum;
  logic signed [17:0]   wsg, wcomp;
  logic signed [PW-1:0] p1, p2;
  logic signed [BW-1:0] vsum, vsh, vsat;
  assign dq    = neg_q[ch_q] ? -$signed({1'b0, n_q[ch_q][QW-1:0]})
                             :  $signed({1'b0, n_q[ch_q][QW-1:0]});
  assign gsum  = SW'(est_q[ch_q]) + SW'(dq);
  assign wsg   = $signed({1'b0, cfg_i.weight});
  assign wcomp = $signed({1'b0, Q16_ONE}) - wsg;
  assign p1    = wsg * gsum;
  assign p2    = wcomp * acc_q[ch_q];
  assign vsum  = BW'(p1_q) + BW'(p2_q) + BW'(32768);
  assign vsh   = vsum >>> 16;
  always_comb begin
    if (vsh > LIM)       vsat = LIM;
    else if (vsh < -LIM) vsat = -LIM;
    else                 vsat = vsh;
  end

  // Flip detection on the new estimates
  logic [EW-1:0] abs_r, abs_p;
  logic          flip;
  assign abs_r = EW'((est_q[0] < 0) ? -est_q[0] : est_q[0]);
  assign abs_p = EW'((est_q[1] < 0) ? -est_q[1] : est_q[1]);
  assign flip  = (CW'(abs_r) > CW'(cfg_i.flip_limit)) ||
                 (CW'(abs_p) > CW'(cfg_i.flip_limit));

  assign q_take_o   = (state_q == ST_IDLE) && q_valid_i;
  assign empty      = !out_valid_q;
  assign out_word_o = out_q;

  // Sequence one sample through the shared units
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      est_q[0]    <= '0;
      est_q[1]    <= '0;
    end else begin
      if (pop && out_valid_q && (state_q != ST_FIN)) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            item_q  <= q_word_i;
            state_q <= ST_SQ_A;
          end
        end
        ST_SQ_A: begin
          sq_q    <= 32'(item_q.accel_y) * 32'(item_q.accel_y);
          state_q <= ST_SQ_B;
        end
        ST_SQ_B: begin
          v_q     <= sq_q + 32'(item_q.accel_z) * 32'(item_q.accel_z);
          r_q     <= '0;
          bit_q   <= 32'h4000_0000;
          sc_q    <= '0;
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          if ({1'b0, v_q} >= rb) begin
            v_q <= 32'({1'b0, v_q} - rb);
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          sc_q  <= sc_q + 4'd1;
          if (sc_q == 4'd15) begin
            cy_q    <= 18'(item_q.accel_y);
            cx_q    <= 18'(item_q.accel_z);
            which_q <= 1'b0;
            state_q <= ST_CINIT;
          end
        end
        ST_CINIT: begin
          zero_q <= (cx_q == '0) && (cy_q == '0);
          i_q    <= '0;
          if (cx_q < 0) begin
            if (cy_q >= 0) begin
              x_q <= ye; y_q <= -xe; z_q <= Z90;
            end else begin
              x_q <= -ye; y_q <= xe; z_q <= -Z90;
            end
          end else begin
            x_q <= xe; y_q <= ye; z_q <= '0;
          end
          state_q <= ST_CITER;
        end
        ST_CITER: begin
          if (y_q < 0) begin
            x_q <= x_q - ysh; y_q <= y_q + xsh; z_q <= z_q - at_s;
          end else begin
            x_q <= x_q + ysh; y_q <= y_q - xsh; z_q <= z_q + at_s;
          end
          i_q <= i_q + 5'd1;
          if (i_q == 5'(NSTEP - 1)) state_q <= ST_CDONE;
        end
        ST_CDONE: begin
          acc_q[which_q] <= zero_q ? '0 : AW'(zr);
          if (!which_q) begin
            cy_q    <= -18'(item_q.accel_x);
            cx_q    <= $signed({1'b0, r_q[16:0]});
            which_q <= 1'b1;
            state_q <= ST_CINIT;
          end else begin
            state_q <= ST_GINIT;
          end
        end
        ST_GINIT: begin
          for (int c = 0; c < 2; c++) begin
            n_q[c]   <= (DW'(mag[c]) << F) + DW'(GYRO_DIVISOR / 2);
            neg_q[c] <= (m[c] < 0);
          end
          state_q <= ST_GDIV;
        end
        ST_GDIV: begin
          for (int c = 0; c < 2; c++) begin
            n_q[c] <= DW'(prod[c] >> RK);
          end
          ch_q    <= 1'b0;
          state_q <= ST_BMUL1;
        end
        ST_BMUL1: begin
          p1_q    <= p1;
          state_q <= ST_BMUL2;
        end
        ST_BMUL2: begin
          p2_q    <= p2;
          state_q <= ST_BSUM;
        end
        ST_BSUM: begin
          est_q[ch_q] <= EW'(vsat);
          if (!ch_q) begin
            ch_q    <= 1'b1;
            state_q <= ST_BMUL1;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || pop) begin
            out_q.roll_angle  <= 16'(est_q[0]);
            out_q.pitch_angle <= 16'(est_q[1]);
            out_q.flipped     <= flip;
            out_valid_q       <= 1'b1;
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/tilt_complementary_filter.sv
// Roll/pitch tilt estimator: one sample word in, one angle word out per sample.
// Each sample passes through the 16-step square root and the one shared CORDIC, which runs
// roll then pitch; the gyro divide is a reciprocal multiply. A two-word queue holds samples
// behind the back end and a result register holds the finished word until it is popped;
// an unpopped result stalls the back end. Settings must be written only while idle; the
// block itself does not enforce it. No clearing pass runs after reset.
module tilt_complementary_filter import tcf_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_word_t              in_word_i,
  output logic                  empty,
  input  logic                  pop,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic     q_valid, q_take;
  in_word_t q_word;
  cfg_t     cfg;

  // Accept words and hold settings
  tcf_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .in_word_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .q_valid_o (q_valid),
    .q_word_o  (q_word),
    .q_take_i  (q_take),
    .cfg_o     (cfg)
  );

  // Compute the filtered angles
  tcf_back #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_word_i  (q_word),
    .q_take_o  (q_take),
    .cfg_i     (cfg),
    .empty,
    .pop,
    .out_word_o
  );

endmodule

### design/tcf_checker.sv
// Port-level checks of the tilt filter result side, bound to the top level.
`include "tilt_complementary_filter_assert.svh"

module tcf_checker import tcf_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_word_t out_word_o
);

  localparam int LIM = 180 << ANGLE_FRAC_BITS;

  int roll_v, pitch_v;
  assign roll_v  = int'(out_word_o.roll_angle);
  assign pitch_v = int'(out_word_o.pitch_angle);

  `TCF_ASSERT_ANY(a_empty_after_reset, clk_i, $rose(rst_ni) |-> empty, "result after reset")
  `TCF_ASSERT(a_hold_word, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_word_o)), "word dropped")
  `TCF_ASSERT(a_roll_range, clk_i, rst_ni, !empty |-> ((LIM > 32767) || (roll_v <= LIM && roll_v >= -LIM)), "roll out of range")
  `TCF_ASSERT(a_pitch_range, clk_i, rst_ni, !empty |-> ((LIM > 32767) || (pitch_v <= LIM && pitch_v >= -LIM)), "pitch out of range")

endmodule

bind tilt_complementary_filter tcf_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_tcf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_word_o (out_word_o)
);
